### design/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg: shared types and constants for the LCG jump-ahead block
// Generator constants, datapath operation codes and the command/status
// structs exchanged between controller and datapath.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] LcgMult = 32'h0003_43FD;
  localparam logic [WordW-1:0] LcgInc  = 32'h0026_9EC3;

  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_LOAD = 3'd1,
    OP_STEP = 3'd2,
    OP_INC  = 3'd3,
    OP_SQR  = 3'd4
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_lsb;
    logic upper_zero;
  } dp_status_t;

endpackage

### design/lcg_if.sv
// ----------------------------------------------------------------------------
// lcg_req_if / lcg_rsp_if: valid/ready channels of the jump-ahead block
// The request carries a seed and a step count, the response the new seed.
// ----------------------------------------------------------------------------
interface lcg_req_if;
  logic                    valid;
  logic                    ready;
  logic [lcg_pkg::WordW-1:0] start_seed;
  logic [lcg_pkg::WordW-1:0] step_count;

  modport source (output valid, output start_seed, output step_count, input ready);
  modport sink   (input valid, input start_seed, input step_count, output ready);
endinterface

interface lcg_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [lcg_pkg::WordW-1:0] advanced_seed;

  modport source (output valid, output advanced_seed, input ready);
  modport sink   (input valid, input advanced_seed, output ready);
endinterface

### design/lcg_datapath.sv
// ----------------------------------------------------------------------------
// lcg_datapath: registers and shared multiplier of the jump-ahead block
// Holds the running seed, the step map for the current bit of the count
// (multiplier and addend) and the remaining count. One 32x32 low-half
// multiply per cycle.
// ----------------------------------------------------------------------------
module lcg_datapath (
  input  logic                      clk,
  input  lcg_pkg::dp_cmd_t          cmd,
  input  logic [lcg_pkg::WordW-1:0] load_seed,
  input  logic [lcg_pkg::WordW-1:0] load_count,
  output lcg_pkg::dp_status_t       status,
  output logic [lcg_pkg::WordW-1:0] seed
);

  logic [lcg_pkg::WordW-1:0] step_mul;
  logic [lcg_pkg::WordW-1:0] step_add;
  logic [lcg_pkg::WordW-1:0] count;

  logic [lcg_pkg::WordW-1:0] op_a;
  logic [lcg_pkg::WordW-1:0] op_b;
  logic [2*lcg_pkg::WordW-1:0] prod_full;
  logic [lcg_pkg::WordW-1:0] prod;

  always_comb begin
    op_a = step_mul;
    op_b = step_mul;
    case (cmd.op)
      lcg_pkg::OP_STEP: begin
        op_a = seed;
        op_b = step_mul;
      end
      lcg_pkg::OP_INC: begin
        op_a = step_mul + lcg_pkg::WordW'(1);
        op_b = step_add;
      end
      default: begin
        op_a = step_mul;
        op_b = step_mul;
      end
    endcase
  end

  assign prod_full = op_a * op_b;
  assign prod      = prod_full[lcg_pkg::WordW-1:0];

  // The power-of-two step maps all commute, so each one whose count bit is
  // set is applied straight to the seed.
  always_ff @(posedge clk) begin
    case (cmd.op)
      lcg_pkg::OP_LOAD: begin
        seed     <= load_seed;
        count    <= load_count;
        step_mul <= lcg_pkg::LcgMult;
        step_add <= lcg_pkg::LcgInc;
      end
      lcg_pkg::OP_STEP: seed <= prod + step_add;
      lcg_pkg::OP_INC:  step_add <= prod;
      lcg_pkg::OP_SQR: begin
        step_mul <= prod;
        count    <= {1'b0, count[lcg_pkg::WordW-1:1]};
      end
      default: ;
    endcase
  end

  assign status.count_zero = (count == '0);
  assign status.count_lsb  = count[0];
  assign status.upper_zero = (count[lcg_pkg::WordW-1:1] == '0);

endmodule

### design/lcg_ctrl.sv
// ----------------------------------------------------------------------------
// lcg_ctrl: sequencer of the jump-ahead block
// Walks the step count one bit at a time and issues the multiply steps to
// the datapath; owns both channel handshakes.
// ----------------------------------------------------------------------------
module lcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  lcg_pkg::dp_status_t status,
  output lcg_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_INC   = 6'b001000,
    ST_SQR   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = lcg_pkg::OP_HOLD;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.op     = lcg_pkg::OP_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.count_zero) begin
          state_next = ST_DONE;
        end else if (status.count_lsb) begin
          state_next = ST_STEP;
        end else begin
          state_next = ST_INC;
        end
      end
      ST_STEP: begin
        cmd.op = lcg_pkg::OP_STEP;
        // After the top set bit no further step map is needed.
        state_next = status.upper_zero ? ST_DONE : ST_INC;
      end
      ST_INC: begin
        cmd.op     = lcg_pkg::OP_INC;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.op     = lcg_pkg::OP_SQR;
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_DONE);

endmodule

### design/lcg_jump_ahead_top.sv
// ----------------------------------------------------------------------------
// lcg_jump_ahead_top: 32-bit LCG jump-ahead
// Advances a seed of x' = x*0x343FD + 0x269EC3 (mod 2^32) by an arbitrary
// step count with square-and-multiply over the bits of the count.
//
//   channel | dir | payload                     | transfer when
//   req     | in  | start_seed, step_count      | req.valid && req.ready
//   rsp     | out | advanced_seed               | rsp.valid && rsp.ready
//
// One request is in flight at a time. The count is walked from its lowest
// bit up to its highest set bit. Every bit position below the highest costs
// a check plus two multiplies to square the step map. Every set bit costs
// one more multiply. All of them share one 32x32 multiplier. A zero count
// goes straight from the check to the response.
// The next request can be taken in the cycle after the response transfer.
// Synchronous reset returns to idle; a stalled response holds its value
// until taken.
// ----------------------------------------------------------------------------
module lcg_jump_ahead_top (
  input  logic      clk,
  input  logic      rst,
  lcg_req_if.sink   req,
  lcg_rsp_if.source rsp
);

  lcg_pkg::dp_cmd_t    cmd;
  lcg_pkg::dp_status_t status;

  lcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcg_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .load_seed  (req.start_seed),
    .load_count (req.step_count),
    .status     (status),
    .seed       (rsp.advanced_seed)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the 32-bit LCG jump-ahead block
// Sends seed/step-count requests with directed corner cases and random
// traffic over four idling phases. A scoreboard predicts each advanced seed
// by square-and-multiply and checks the responses in order.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [lcg_pkg::WordW-1:0] word_t;

  localparam int RandomItems = 1540;
  localparam int Phases      = 4;
  localparam int DrainCycles = 160;

  class seed_scoreboard;
    word_t       expected_seeds[$];
    int unsigned errors = 0;

    // Applies step_count generator steps in one jump: the step map (a, c)
    // is squared per bit and folded into the total where the bit is set.
    function word_t advance_seed(word_t seed, word_t count);
      word_t total_mul;
      word_t total_add;
      word_t step_mul;
      word_t step_add;
      total_mul = 1;
      total_add = 0;
      step_mul  = lcg_pkg::LcgMult;
      step_add  = lcg_pkg::LcgInc;
      for (int idx = 0; idx < lcg_pkg::WordW; idx++) begin
        if (count[idx]) begin
          total_mul = total_mul * step_mul;
          total_add = total_add * step_mul + step_add;
        end
        step_add = (step_mul + 1) * step_add;
        step_mul = step_mul * step_mul;
      end
      return total_mul * seed + total_add;
    endfunction

    function void note_request(word_t seed, word_t count);
      expected_seeds = {expected_seeds, advance_seed(seed, count)};
    endfunction

    function void check_response(word_t actual);
      word_t expected;
      if (expected_seeds.size() == 0) begin
        $error("advanced_seed: unexpected response, actual %h", actual);
        errors++;
        return;
      end
      expected = expected_seeds.pop_front();
      if (actual !== expected) begin
        $error("advanced_seed: expected %h, actual %h", expected, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_seeds.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  lcg_req_if req_ch ();
  lcg_rsp_if rsp_ch ();

  lcg_jump_ahead_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  seed_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are observed here, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.start_seed, req_ch.step_count);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response(rsp_ch.advanced_seed);
      end
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input word_t seed, input word_t count);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.start_seed <= seed;
    req_ch.step_count <= count;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_all_returned();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic word_t pick_count();
    int unsigned k;
    k = $urandom_range(lcg_pkg::WordW - 1);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4:          return $urandom_range(20);
      5:          return word_t'(1) << k;
      6:          return (word_t'(1) << k) - 1;
      7:          return ~(word_t'(1) << k);
      8:          return $urandom | 32'h8000_0000;
      default:    return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  function automatic word_t pick_seed();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.start_seed = '0;
    req_ch.step_count = '0;
    rsp_ch.ready      = 1'b0;
    rst               = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero count, single steps, the widest counts and alternating patterns.
    send_request(32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h1234_5678, 32'h0000_0000);
    send_request(32'h0000_0000, 32'h0000_0001);
    send_request(32'hFFFF_FFFF, 32'h0000_0001);
    send_request(32'h0000_0001, 32'h0000_0002);
    send_request(32'hDEAD_BEEF, 32'h0000_0003);
    send_request(32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'h8000_0000);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'hA5A5_A5A5, 32'h5555_5555);
    send_request(32'h5A5A_5A5A, 32'hAAAA_AAAA);
    send_request(32'h0BAD_F00D, 32'h0001_0000);
    send_request(32'hCAFE_0001, 32'hFFFF_FFFE);
    wait_all_returned();

    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
      for (int n = 0; n < RandomItems / Phases; n++) begin
        send_request(pick_seed(), pick_count());
      end
      // The sender holds off here until every response is back.
      wait_all_returned();
    end

    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
